// ===== rtl/sparse_table_range_minimum_macros.svh =====
// Assertion macros shared by the sparse table range-minimum RTL
`ifndef SPARSE_TABLE_RANGE_MINIMUM_MACROS_SVH
`define SPARSE_TABLE_RANGE_MINIMUM_MACROS_SVH

// Same-cycle implication, checked out of reset
`define STRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define STRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/strm_pkg.sv =====
// Shared constants, types and helpers for the sparse table range-minimum engine
package strm_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int LEVELS      = 11;
    localparam int VALUE_WIDTH = 32;

    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int DEPTH  = LEVELS * MAX_LEN;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_APPEND = 2'd0;
    localparam t_op OP_QUERY  = 2'd1;
    localparam t_op OP_CLEAR  = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Floor of log2 of a nonzero length, saturated at the top level
    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] len);
        logic [LVL_W-1:0] k;
        k = '0;
        for (int i = 1; i < LEVELS; i++) begin
            if ((len >> i) != '0) begin
                k = LVL_W'(i);
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/strm_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data
module strm_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sparse_table_range_minimum.sv =====
// Top level of the sparse table range-minimum engine: control sequencer and table RAM
//
// Command channel: present i_operation, i_value, i_left, i_right with start high;
// the beat is taken at a rising edge where busy is low. Results appear on
// o_minimum and o_status for one cycle with o_strobe high; the receiver cannot
// stall them, so nothing is ever held back.
// Append: level 0 is written on acceptance, then one level per cycle walks up
// the table (each read of level j overlaps the write of level j), so an append at
// position p writes levels 0 to min(floor(log2(p+1)), 10) and gives no result.
// An append when full answers with status 2 in the next cycle.
// Query: two reads of the single RAM read port, issued on acceptance and in S_Q1,
// result strobed out of S_Q2; an out-of-range query answers with status 1 in the next cycle.
// Clear and unused codes give no result.
// The single RAM read port sets the query rate; the level walk sets the append rate.
// Reset clears the loaded count and control state; table contents are undefined
// until written and need no clearing pass.
module sparse_table_range_minimum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_operation,
    input  logic signed [strm_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic [strm_pkg::IDX_W-1:0]          i_left,
    input  logic [strm_pkg::IDX_W-1:0]          i_right,
    output logic                                o_strobe,
    output logic signed [strm_pkg::VALUE_WIDTH-1:0] o_minimum,
    output logic [1:0]                          o_status
);

    localparam int VW    = strm_pkg::VALUE_WIDTH;
    localparam int IDX_W = strm_pkg::IDX_W;
    localparam int CNT_W = strm_pkg::CNT_W;
    localparam int LVL_W = strm_pkg::LVL_W;
    localparam int AW    = strm_pkg::ADDR_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_APP  = 2'd1;
    localparam logic [1:0] S_Q1   = 2'd2;
    localparam logic [1:0] S_Q2   = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_p1, n_p1;
    logic [LVL_W-1:0]     r_lvl, n_lvl;
    logic signed [VW-1:0] r_min, n_min;
    logic [AW-1:0]        r_baddr, n_baddr;
    logic                 r_strobe, n_strobe;
    logic signed [VW-1:0] r_minimum, n_minimum;
    logic [1:0]           r_status, n_status;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [VW-1:0]        mem_wdata, mem_rdata;
    logic signed [VW-1:0] rd_s;

    logic [IDX_W-1:0]     q_lo, q_hi;
    logic                 q_bad;
    logic [CNT_W-1:0]     q_len;
    logic [LVL_W-1:0]     q_k;
    logic [CNT_W-1:0]     q_bstart;
    logic                 accept;

    logic [CNT_W:0]       a_p1x, a_pw, a_pw2, a_ws, a_rs;
    logic signed [VW-1:0] a_m;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign rd_s   = $signed(mem_rdata);

    assign q_lo     = (i_left < i_right) ? i_left : i_right;
    assign q_hi     = (i_left < i_right) ? i_right : i_left;
    assign q_bad    = (CNT_W'(q_hi) >= r_count);
    assign q_len    = CNT_W'(q_hi) - CNT_W'(q_lo) + CNT_W'(1);
    assign q_k      = strm_pkg::floor_log2(q_len);
    assign q_bstart = CNT_W'(q_hi) + CNT_W'(1) - (CNT_W'(1) << q_k);

    assign a_p1x = {1'b0, r_p1};
    assign a_pw  = (CNT_W + 1)'(1) << r_lvl;
    assign a_pw2 = (CNT_W + 1)'(1) << (r_lvl + LVL_W'(1));
    assign a_ws  = a_p1x - a_pw;
    assign a_rs  = a_p1x - a_pw2;
    assign a_m   = (rd_s < r_min) ? rd_s : r_min;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_p1      = r_p1;
        n_lvl     = r_lvl;
        n_min     = r_min;
        n_baddr   = r_baddr;
        n_strobe  = 1'b0;
        n_minimum = r_minimum;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        strm_pkg::OP_APPEND: begin
                            if (r_count >= CNT_W'(strm_pkg::MAX_LEN)) begin
                                n_strobe  = 1'b1;
                                n_minimum = '0;
                                n_status  = strm_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = {LVL_W'(0), r_count[IDX_W-1:0]};
                                mem_wdata = i_value;
                                n_min     = i_value;
                                n_count   = r_count + CNT_W'(1);
                                n_p1      = r_count + CNT_W'(1);
                                // level 1 needs the level-0 entry just before this one
                                if (r_count != '0) begin
                                    mem_re    = 1'b1;
                                    mem_raddr = {LVL_W'(0),
                                                 IDX_W'(r_count - CNT_W'(1))};
                                    n_lvl     = LVL_W'(1);
                                    n_state   = S_APP;
                                end
                            end
                        end
                        strm_pkg::OP_QUERY: begin
                            if (q_bad) begin
                                n_strobe  = 1'b1;
                                n_minimum = '0;
                                n_status  = strm_pkg::ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = {q_k, q_lo};
                                n_baddr   = {q_k, q_bstart[IDX_W-1:0]};
                                n_state   = S_Q1;
                            end
                        end
                        strm_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_APP: begin
                // fold the older half-window into the running minimum, write level r_lvl
                mem_we    = 1'b1;
                mem_waddr = {r_lvl, a_ws[IDX_W-1:0]};
                mem_wdata = a_m;
                n_min     = a_m;
                if ((r_lvl < LVL_W'(strm_pkg::LEVELS - 1)) && (a_p1x >= a_pw2)) begin
                    mem_re    = 1'b1;
                    mem_raddr = {r_lvl, a_rs[IDX_W-1:0]};
                    n_lvl     = r_lvl + LVL_W'(1);
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_Q1: begin
                mem_re    = 1'b1;
                mem_raddr = r_baddr;
                n_min     = rd_s;
                n_state   = S_Q2;
            end
            S_Q2: begin
                n_strobe  = 1'b1;
                n_minimum = (rd_s < r_min) ? rd_s : r_min;
                n_status  = strm_pkg::ST_OK;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_lvl    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_lvl    <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1      <= n_p1;
        r_min     <= n_min;
        r_baddr   <= n_baddr;
        r_minimum <= n_minimum;
        r_status  <= n_status;
    end

    // Writes and reads of one cycle never hit the same entry, so no bypass is needed
    strm_ram #(
        .DEPTH  (strm_pkg::DEPTH),
        .ADDR_W (AW),
        .DATA_W (VW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_strobe  = r_strobe;
    assign o_minimum = r_minimum;
    assign o_status  = r_status;

`include "sparse_table_range_minimum_macros.svh"

    `STRM_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, r_strobe, r_state == S_IDLE, "result beat while sequencer busy")
    `STRM_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(strm_pkg::MAX_LEN), "loaded count above capacity")
    `STRM_ASSERT_NEXT(a_range_err, i_clk, i_rst_n, accept && i_operation == strm_pkg::OP_QUERY && q_bad, r_strobe && r_status == strm_pkg::ST_RANGE && r_minimum == '0, "range error not reported")
    `STRM_ASSERT_NOW(a_app_lvl, i_clk, i_rst_n, r_state == S_APP, r_lvl != '0 && r_lvl < LVL_W'(strm_pkg::LEVELS), "level walk out of bounds")

endmodule

// ===== sim/sparse_table_range_minimum_tb.sv =====
// Self-checking testbench for the sparse table range-minimum engine
module sparse_table_range_minimum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        logic [9:0]  left;
        logic [9:0]  right;
    } t_cmd;

    typedef struct packed {
        logic [31:0] minimum;
        logic [1:0]  status;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic signed [31:0] i_value;
    logic [9:0]  i_left;
    logic [9:0]  i_right;
    logic        o_strobe;
    logic signed [31:0] o_minimum;
    logic [1:0]  o_status;

    sparse_table_range_minimum i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_value(i_value), .i_left(i_left),
        .i_right(i_right), .o_strobe(o_strobe), .o_minimum(o_minimum),
        .o_status(o_status)
    );

    t_cmd    pending_cmds[$];
    t_answer expected_answers[$];
    logic signed [31:0] stored_values[strm_pkg::MAX_LEN];
    int unsigned fill_count = 0;
    int      error_count = 0;
    int      send_idle_pct;
    bit      hold_send;
    int      cycle_count = 0;
    int      query_count, append_count, full_count, range_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Model: minimum over the two overlapping power-of-two windows
    function automatic logic signed [31:0] window_min(int unsigned lo, int unsigned hi);
        int unsigned k;
        int unsigned len;
        logic signed [31:0] m;
        len = hi - lo + 1;
        k = 0;
        while (k + 1 < strm_pkg::LEVELS && (len >> (k + 1)) != 0) k++;
        m = stored_values[lo];
        for (int unsigned i = lo; i < lo + (1 << k); i++)
            if (stored_values[i] < m) m = stored_values[i];
        for (int unsigned i = hi + 1 - (1 << k); i <= hi; i++)
            if (stored_values[i] < m) m = stored_values[i];
        return m;
    endfunction

    task automatic predict_beat(input t_cmd c);
        int unsigned lo, hi;
        case (c.op)
            strm_pkg::OP_APPEND: begin
                if (fill_count >= strm_pkg::MAX_LEN) begin
                    expected_answers.push_back('{32'd0, strm_pkg::ST_FULL});
                    full_count++;
                end else begin
                    stored_values[fill_count] = c.value;
                    fill_count++;
                    append_count++;
                end
            end
            strm_pkg::OP_QUERY: begin
                lo = (c.left < c.right) ? c.left : c.right;
                hi = (c.left < c.right) ? c.right : c.left;
                if (hi >= fill_count) begin
                    expected_answers.push_back('{32'd0, strm_pkg::ST_RANGE});
                    range_count++;
                end else begin
                    expected_answers.push_back('{window_min(lo, hi), strm_pkg::ST_OK});
                    query_count++;
                end
            end
            strm_pkg::OP_CLEAR: fill_count = 0;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %0s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Driver: hold the beat until busy drops
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_operation <= strm_pkg::OP_CLEAR;
            i_value     <= '0;
            i_left      <= '0;
            i_right     <= '0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else begin
            if (start) predict_beat({i_operation, i_value, i_left, i_right});
            if (pending_cmds.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
                t_cmd c;
                c = pending_cmds.pop_front();
                start       <= 1'b1;
                i_operation <= c.op;
                i_value     <= c.value;
                i_left      <= c.left;
                i_right     <= c.right;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_answer want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result", o_minimum, 0);
            end else begin
                want = expected_answers.pop_front();
                if (o_minimum !== want.minimum)
                    report_mismatch("minimum", o_minimum, want.minimum);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
        if (cycle_count > 2000000) begin
            $display("timeout with %0d results outstanding", expected_answers.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Queries aimed mostly inside the loaded part, ends in either order
    function automatic t_cmd rand_query(int unsigned n);
        t_cmd c;
        c.op = strm_pkg::OP_QUERY;
        c.value = $urandom;
        if (n > 0 && $urandom_range(9) > 0) begin
            c.left  = 10'($urandom_range(n - 1));
            c.right = 10'($urandom_range(n - 1));
        end else begin
            c.left  = 10'($urandom);
            c.right = 10'($urandom);
        end
        return c;
    endfunction

    function automatic bit answers_pending();
        return expected_answers.size() > 0;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || answers_pending()) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int unsigned n;
        t_cmd c;
        i_rst_n = 1'b0;
        hold_send = 1'b0;
        send_idle_pct = 14;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty query, extremes, swap, unused code, clear
        pending_cmds.push_back('{strm_pkg::OP_QUERY, 32'd0, 10'd0, 10'd0});
        pending_cmds.push_back('{strm_pkg::OP_APPEND, 32'h7fff_ffff, 10'd0, 10'd0});
        pending_cmds.push_back('{strm_pkg::OP_APPEND, 32'h8000_0000, 10'd0, 10'd0});
        pending_cmds.push_back('{strm_pkg::OP_APPEND, 32'hffff_ffff, 10'd1023, 10'd1023});
        pending_cmds.push_back('{strm_pkg::OP_APPEND, 32'd5, 10'd0, 10'd0});
        pending_cmds.push_back('{strm_pkg::OP_QUERY, 32'd0, 10'd0, 10'd0});
        pending_cmds.push_back('{strm_pkg::OP_QUERY, 32'd0, 10'd3, 10'd0});
        pending_cmds.push_back('{strm_pkg::OP_QUERY, 32'd0, 10'd2, 10'd3});
        pending_cmds.push_back('{strm_pkg::OP_QUERY, 32'd0, 10'd0, 10'd4});
        pending_cmds.push_back('{strm_pkg::OP_QUERY, 32'hffff_ffff, 10'd1023, 10'd1023});
        pending_cmds.push_back('{2'd3, 32'hffff_ffff, 10'd1023, 10'd1023});
        pending_cmds.push_back('{strm_pkg::OP_CLEAR, 32'd0, 10'd0, 10'd0});
        pending_cmds.push_back('{strm_pkg::OP_QUERY, 32'd0, 10'd0, 10'd0});
        // Fill to capacity, then overflow and full-range queries
        for (int i = 0; i < strm_pkg::MAX_LEN + 2; i++)
            pending_cmds.push_back('{strm_pkg::OP_APPEND, rand_value(), 10'd0, 10'd0});
        pending_cmds.push_back('{strm_pkg::OP_QUERY, 32'd0, 10'd0, 10'd1023});
        pending_cmds.push_back('{strm_pkg::OP_QUERY, 32'd0, 10'd1023, 10'd512});
        pending_cmds.push_back('{strm_pkg::OP_QUERY, 32'd0, 10'd511, 10'd0});
        for (int i = 0; i < 150; i++) pending_cmds.push_back(rand_query(strm_pkg::MAX_LEN));

        // Pause until every result is back
        hold_send = 1'b0;
        wait_drained();

        // Random: small fills with queries, occasional clears and noise
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 76 : 0;
            n = 0;
            pending_cmds.push_back('{strm_pkg::OP_CLEAR, 32'd0, 10'd0, 10'd0});
            for (int i = 0; i < 250; i++) begin
                case ($urandom_range(19))
                    0: begin
                        pending_cmds.push_back('{strm_pkg::OP_CLEAR, $urandom, 10'($urandom),
                                                 10'($urandom)});
                        n = 0;
                    end
                    1: pending_cmds.push_back('{2'd3, $urandom, 10'($urandom), 10'($urandom)});
                    2, 3, 4, 5, 6, 7, 8, 9: begin
                        c = '{strm_pkg::OP_APPEND, rand_value(), 10'($urandom),
                              10'($urandom)};
                        pending_cmds.push_back(c);
                        if (n < strm_pkg::MAX_LEN) n++;
                    end
                    default: pending_cmds.push_back(rand_query(n));
                endcase
            end
            wait_drained();
        end

        $display("covered %0d appends, %0d good queries, %0d range errors, %0d full appends",
                 append_count, query_count, range_count, full_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
